FILE: rtl/hfsc_pkg.sv
// Shared types and constants for the fan setpoint controller.
// Used by hfsc_step and hvac_fan_setpoint_controller; no dependencies.
package hfsc_pkg;

  localparam int unsigned CountW  = 24;
  localparam int unsigned DistW   = 9;
  localparam int unsigned JoyW    = 12;
  localparam int unsigned TempW   = 12;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned SetW    = 7;
  localparam int unsigned WarnW   = 2;
  localparam int unsigned ErrW    = 14;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgDataW = 24;

  // configuration register indexes
  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgNear    = 1'b1;

  // item kinds
  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // warning codes
  localparam logic [WarnW-1:0] WarnNone  = 2'd0;
  localparam logic [WarnW-1:0] WarnUpper = 2'd1;
  localparam logic [WarnW-1:0] WarnLower = 2'd2;

  localparam logic [JoyW-1:0] JoyBreakY   = 12'd3060;
  localparam logic [JoyW-1:0] JoyLow      = 12'd20;
  localparam logic [JoyW-1:0] JoyHighXUp  = 12'd2800;
  localparam logic [JoyW-1:0] JoyHighYDn  = 12'd2800;
  localparam logic [JoyW-1:0] JoyFanDnX   = 12'd2920;
  localparam logic [JoyW-1:0] JoyFanDnY   = 12'd2880;

  localparam logic [SetW-1:0]   SetpointMax   = 7'd64;
  localparam logic [SetW-1:0]   SetpointMin   = 7'd32;
  localparam logic [SetW-1:0]   SetpointReset = 7'd42;
  localparam logic [LevelW-1:0] LevelMax      = 3'd5;
  localparam logic [LevelW-1:0] LevelMin      = 3'd1;
  localparam logic [LevelW-1:0] LevelReset    = 3'd2;
  localparam logic [CountW-1:0] CountMax      = 24'hFFFFFF;

  localparam logic [CountW-1:0] TimeoutReset = 24'd5000;
  localparam logic [DistW-1:0]  NearReset    = 9'd50;

  localparam logic signed [ErrW-1:0] Band5 = 14'sd100;
  localparam logic signed [ErrW-1:0] Band4 = 14'sd60;
  localparam logic signed [ErrW-1:0] Band3 = 14'sd30;
  localparam logic signed [ErrW-1:0] Band2 = 14'sd10;

  typedef struct packed {
    logic              power;
    logic              heater;
    logic              auto_fan;
    logic              vent;
    logic [LevelW-1:0] wind;
    logic [SetW-1:0]   setpoint;
    logic              joy_wait;
    logic              armed;
    logic [CountW-1:0] count;
  } state_t;

  typedef struct packed {
    logic                    cmd;
    logic [JoyW-1:0]         joy_x;
    logic [JoyW-1:0]         joy_y;
    logic                    mode_press;
    logic                    auto_press;
    logic                    power_press;
    logic signed [TempW-1:0] room_temp;
    logic [DistW-1:0]        distance_cm;
  } item_t;

  typedef struct packed {
    logic              powered;
    logic              heat_mode;
    logic              auto_mode;
    logic              vent_open;
    logic [LevelW-1:0] fan_level;
    logic              fan_reverse;
    logic [SetW-1:0]   setpoint_half;
    logic [WarnW-1:0]  warning;
    logic              timed_out;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] timeout;
    logic [DistW-1:0]  near;
  } cfg_t;

endpackage

FILE: rtl/hfsc_step.sv
// Next-state and result logic for one sample or tick transaction.
// Depends on hfsc_pkg; purely combinational.
module hfsc_step (
  input  hfsc_pkg::state_t  state_i,
  input  hfsc_pkg::item_t   item_i,
  input  hfsc_pkg::cfg_t    cfg_i,
  output hfsc_pkg::state_t  state_o,
  output hfsc_pkg::result_t result_o,
  output logic              has_res_o
);

  always_comb begin
    hfsc_pkg::state_t ns;
    logic [hfsc_pkg::WarnW-1:0] warn;
    logic tout;
    logic res;
    logic pass_done;
    logic [hfsc_pkg::CountW-1:0] limit;
    logic [9:0] sp10u;
    logic signed [hfsc_pkg::ErrW-1:0] sp10s;
    logic signed [hfsc_pkg::ErrW-1:0] room;
    logic signed [hfsc_pkg::ErrW-1:0] err;

    ns        = state_i;
    warn      = hfsc_pkg::WarnNone;
    tout      = 1'b0;
    res       = 1'b0;
    pass_done = 1'b0;
    limit     = (cfg_i.timeout == '0) ? hfsc_pkg::CountW'(1) : cfg_i.timeout;
    sp10u     = '0;
    sp10s     = '0;
    room      = {{(hfsc_pkg::ErrW-hfsc_pkg::TempW){item_i.room_temp[hfsc_pkg::TempW-1]}},
                 item_i.room_temp};
    err       = '0;

    if (item_i.cmd == hfsc_pkg::CmdTick) begin
      if (state_i.power && state_i.armed) begin
        if (state_i.count < hfsc_pkg::CountMax) ns.count = state_i.count + 1'b1;
        if (ns.count >= limit) begin
          ns.power    = 1'b0;
          ns.armed    = 1'b0;
          ns.count    = '0;
          ns.joy_wait = 1'b0;
          tout        = 1'b1;
          res         = 1'b1;
        end
      end
    end else if (!state_i.power) begin
      if (item_i.power_press) begin
        ns.power     = 1'b1;
        ns.heater    = 1'b0;
        ns.auto_fan  = 1'b1;
        ns.vent      = 1'b1;
        ns.armed     = 1'b0;
        ns.count     = '0;
        ns.joy_wait  = 1'b0;
        res          = 1'b1;
      end
    end else begin
      // presence check only opens a fresh pass
      if (!state_i.joy_wait) begin
        if (item_i.distance_cm >= cfg_i.near) begin
          if (!state_i.armed) begin
            ns.armed = 1'b1;
            ns.count = '0;
          end
        end else if (state_i.armed) begin
          ns.armed = 1'b0;
          ns.count = '0;
        end
      end

      pass_done = 1'b1;
      if (item_i.joy_y > hfsc_pkg::JoyBreakY) begin
        pass_done = 1'b1;
      end else if (item_i.joy_x < hfsc_pkg::JoyLow && item_i.joy_y < hfsc_pkg::JoyLow) begin
        if (state_i.setpoint >= hfsc_pkg::SetpointMax) warn = hfsc_pkg::WarnUpper;
        else ns.setpoint = state_i.setpoint + 1'b1;
      end else if (item_i.joy_x > hfsc_pkg::JoyHighXUp &&
                   item_i.joy_y < hfsc_pkg::JoyLow) begin
        if (state_i.wind >= hfsc_pkg::LevelMax) warn = hfsc_pkg::WarnUpper;
        else ns.wind = state_i.wind + 1'b1;
        ns.auto_fan = 1'b0;
      end else if (item_i.joy_x < hfsc_pkg::JoyLow &&
                   item_i.joy_y > hfsc_pkg::JoyHighYDn) begin
        if (state_i.setpoint <= hfsc_pkg::SetpointMin) warn = hfsc_pkg::WarnLower;
        else ns.setpoint = state_i.setpoint - 1'b1;
      end else if (item_i.joy_x > hfsc_pkg::JoyFanDnX &&
                   item_i.joy_y > hfsc_pkg::JoyFanDnY) begin
        if (state_i.wind <= hfsc_pkg::LevelMin) warn = hfsc_pkg::WarnLower;
        else ns.wind = state_i.wind - 1'b1;
        ns.auto_fan = 1'b0;
      end else begin
        // hold the gesture wait; buttons of this sample are ignored
        ns.joy_wait = 1'b1;
        pass_done   = 1'b0;
      end

      if (pass_done) begin
        ns.joy_wait = 1'b0;
        res         = 1'b1;
        if (item_i.mode_press) ns.heater = !ns.heater;
        if (item_i.auto_press) begin
          ns.auto_fan = !ns.auto_fan;
          ns.vent     = ns.auto_fan;
        end
        sp10u = {1'b0, ns.setpoint, 2'b00} + {3'b000, ns.setpoint};
        sp10s = $signed({{(hfsc_pkg::ErrW-10){1'b0}}, sp10u});
        err   = ns.heater ? (sp10s - room) : (room - sp10s);
        if (ns.auto_fan) begin
          if (err >= hfsc_pkg::Band5)      ns.wind = 3'd5;
          else if (err >= hfsc_pkg::Band4) ns.wind = 3'd4;
          else if (err >= hfsc_pkg::Band3) ns.wind = 3'd3;
          else if (err >= hfsc_pkg::Band2) ns.wind = 3'd2;
          else                             ns.wind = 3'd1;
        end
        if (item_i.power_press) begin
          ns.power    = 1'b0;
          ns.armed    = 1'b0;
          ns.count    = '0;
          ns.joy_wait = 1'b0;
        end
      end
    end

    state_o                = ns;
    has_res_o              = res;
    result_o.powered       = ns.power;
    result_o.heat_mode     = ns.heater;
    result_o.auto_mode     = ns.auto_fan;
    result_o.vent_open     = ns.vent;
    result_o.fan_level     = ns.power ? ns.wind : '0;
    result_o.fan_reverse   = ns.power && ns.heater;
    result_o.setpoint_half = ns.setpoint;
    result_o.warning       = warn;
    result_o.timed_out     = tout;
  end

endmodule

FILE: rtl/hvac_fan_setpoint_controller.sv
// Top level of the fan setpoint controller: input register, state and
// result register around hfsc_step. Depends on hfsc_pkg and hfsc_step.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid_i/tready_o     tdata: readings, tuser: cmd
// m_axis    out  m_axis_tvalid_o/tready_i     tdata: status, tuser: timed_out
// cfg       in   cfg_we_i (no handshake)      cfg_index_i, cfg_data_i
//
// One transaction per cycle unless a stall on m_axis holds a result: an
// accepted item is held in the input register, its state update and result
// are computed combinationally from it, and the result is then registered
// in the output register. Reset loads the state defaults, clears the valid
// flags and loads the register defaults. A stall on m_axis holds only items
// that produce a result; items that produce none keep draining, so the
// input side keeps accepting while the held item gives no result.
module hvac_fan_setpoint_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // joy_x[11:0] joy_y[23:12] mode_press[24] auto_press[25] power_press[26]
  // room_temp[38:27] distance_cm[47:39]
  input  logic [hfsc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // powered[0] heat_mode[1] auto_mode[2] vent_open[3] fan_level[6:4]
  // fan_reverse[7] setpoint_half[14:8] warning[16:15], zero above
  output logic [hfsc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // timed_out[0]
  output logic                          m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [hfsc_pkg::CfgDataW-1:0] cfg_data_i
);

  hfsc_pkg::cfg_t    cfg_q;
  hfsc_pkg::state_t  state_q, state_d;
  hfsc_pkg::item_t   item_q;
  hfsc_pkg::result_t res_d, res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              has_res;
  logic              adv;
  logic              in_acc;

  hfsc_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d),
    .has_res_o(has_res)
  );

  // advance the held item unless its result would overwrite a waiting one
  assign adv             = in_valid_q && (!has_res || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= hfsc_pkg::TimeoutReset;
      cfg_q.near    <= hfsc_pkg::NearReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hfsc_pkg::CfgTimeout: cfg_q.timeout <= cfg_data_i;
        hfsc_pkg::CfgNear:    cfg_q.near    <= cfg_data_i[hfsc_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.power     <= 1'b0;
      state_q.heater    <= 1'b0;
      state_q.auto_fan  <= 1'b1;
      state_q.vent      <= 1'b0;
      state_q.wind      <= hfsc_pkg::LevelReset;
      state_q.setpoint  <= hfsc_pkg::SetpointReset;
      state_q.joy_wait  <= 1'b0;
      state_q.armed     <= 1'b0;
      state_q.count     <= '0;
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (adv) state_q <= state_d;
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (adv && has_res) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.cmd         <= s_axis_tuser_i;
      item_q.joy_x       <= s_axis_tdata_i[11:0];
      item_q.joy_y       <= s_axis_tdata_i[23:12];
      item_q.mode_press  <= s_axis_tdata_i[24];
      item_q.auto_press  <= s_axis_tdata_i[25];
      item_q.power_press <= s_axis_tdata_i[26];
      item_q.room_temp   <= s_axis_tdata_i[38:27];
      item_q.distance_cm <= s_axis_tdata_i[47:39];
    end
    if (adv && has_res) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, res_q.warning, res_q.setpoint_half, res_q.fan_reverse,
                            res_q.fan_level, res_q.vent_open, res_q.auto_mode,
                            res_q.heat_mode, res_q.powered};
  assign m_axis_tuser_o  = res_q.timed_out;

`ifndef ASSERT_OFF
  a_off_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.power |-> (!state_q.armed && state_q.count == '0 && !state_q.joy_wait))
    else $error("timer or gesture wait left active while powered off");

  a_setpoint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.setpoint >= hfsc_pkg::SetpointMin && state_q.setpoint <= hfsc_pkg::SetpointMax))
    else $error("setpoint out of range");

  a_timeout_is_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (!res_q.powered && res_q.warning == hfsc_pkg::WarnNone))
    else $error("absence result not a power off");

  a_off_fan_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res_q.powered) |-> (res_q.fan_level == '0 && !res_q.fan_reverse))
    else $error("fan driven while powered off");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("waiting result overwritten");
`endif

endmodule
